FILE: hdl/dtr_pkg.sv
package dtr_pkg;

  localparam int NumW   = 60;   // 2*|n|*2^sh + |w| fits here
  localparam int DenW   = 49;   // 2*|w|
  localparam int QuoW   = 32;
  localparam int ProdW  = 48;

  typedef enum logic [2:0] {
    REG_OFFSET_X    = 3'd0,
    REG_OFFSET_Y    = 3'd1,
    REG_FOCAL_TERM  = 3'd2,
    REG_DISP_GAIN   = 3'd3,
    REG_W_OFFSET    = 3'd4,
    REG_HANDLE_MISS = 3'd5,
    REG_MISSING_D   = 3'd6,
    REG_OUT_MODE    = 3'd7
  } reg_e;

  localparam logic [1:0] MODE_Q16   = 2'd0;
  localparam logic [1:0] MODE_INT32 = 2'd1;
  localparam logic [1:0] MODE_INT16 = 2'd2;

  localparam logic [31:0] BIG_Z_Q16 = 32'd655360000;
  localparam logic [31:0] BIG_Z_INT = 32'd10000;

  // one coordinate's division in flight
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [QuoW-1:0] quo;
    logic            ovf;   // quotient of 2^32 or more, or zero W with nonzero numerator
    logic            zq;    // result forced to zero
    logic            neg;
  } coord_t;

  function automatic coord_t div_step(coord_t c, logic [DenW-1:0] den, int k);
    logic [DenW+QuoW:0] dd;
    logic [DenW+QuoW:0] rr;
    coord_t o;
    dd = (DenW + QuoW + 1)'(den) << k;
    rr = (DenW + QuoW + 1)'(c.rem);
    o  = c;
    if (rr >= dd) begin
      o.rem = NumW'(rr - dd);
      o.quo = c.quo | (QuoW'(1) << k);
    end
    return o;
  endfunction

endpackage

FILE: hdl/disparity_to_3d_reproject.sv
// Disparity to 3D reprojection. One pixel transaction may start every cycle (busy stays
// low) and its point leaves on done_o after these stages: three stages form W, the
// numerators and the rounding-biased dividends, 32 stages of restoring division produce
// one quotient bit each for X, Y and Z in parallel, and one stage saturates and selects
// the output format. The receiver cannot stall: every result is valid for one cycle only.
// Write configuration only while no transaction is in flight.
module disparity_to_3d_reproject #(
  parameter int COORD_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic signed [15:0] disparity_i,
  output logic        done_o,
  output logic signed [31:0] point_x_o,
  output logic signed [31:0] point_y_o,
  output logic signed [31:0] point_z_o,
  output logic        w_zero_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int UseBits = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int DivStg  = dtr_pkg::QuoW;
  localparam int Lat     = DivStg + 4;

  // configuration
  logic signed [31:0] offset_x_q, offset_y_q, focal_q, gain_q, w_off_q;
  logic               handle_miss_q;
  logic [15:0]        miss_d_q;
  logic [1:0]         out_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q    <= '0;
      offset_y_q    <= '0;
      focal_q       <= 32'sd65536;
      gain_q        <= 32'sd16777216;
      w_off_q       <= '0;
      handle_miss_q <= 1'b0;
      miss_d_q      <= 16'h8000;
      out_mode_q    <= dtr_pkg::MODE_Q16;
    end else if (cfg_we_i) begin
      case (dtr_pkg::reg_e'(cfg_addr_i))
        dtr_pkg::REG_OFFSET_X:    offset_x_q    <= cfg_wdata_i;
        dtr_pkg::REG_OFFSET_Y:    offset_y_q    <= cfg_wdata_i;
        dtr_pkg::REG_FOCAL_TERM:  focal_q       <= cfg_wdata_i;
        dtr_pkg::REG_DISP_GAIN:   gain_q        <= cfg_wdata_i;
        dtr_pkg::REG_W_OFFSET:    w_off_q       <= cfg_wdata_i;
        dtr_pkg::REG_HANDLE_MISS: handle_miss_q <= cfg_wdata_i[0];
        dtr_pkg::REG_MISSING_D:   miss_d_q      <= cfg_wdata_i[15:0];
        dtr_pkg::REG_OUT_MODE:    out_mode_q    <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic short_q;  // modes 1 and 2 shift by 8, else by 24
  assign short_q = (out_mode_q == dtr_pkg::MODE_INT32) || (out_mode_q == dtr_pkg::MODE_INT16);

  // stage 1: product
  logic                              v1_q, v2_q;
  logic signed [dtr_pkg::ProdW-1:0]  prod1_q;
  logic [UseBits-1:0]                px1_q, py1_q, px2_dummy;
  logic                              miss1_q, miss2_q;
  // stage 2: W and numerators
  logic signed [dtr_pkg::ProdW:0]    w2_q;
  logic signed [33:0]                nx2_q, ny2_q;

  assign px2_dummy = px1_q;

  // division pipeline
  dtr_pkg::coord_t          dv_q   [0:DivStg][3];
  logic [dtr_pkg::DenW-1:0] den_q  [0:DivStg-1];
  logic                     vd_q   [0:DivStg];
  logic                     miss_q [0:DivStg];
  logic                     wz_q   [0:DivStg];

  // stage 3 comb
  logic signed [33:0]       num3 [3];
  logic [dtr_pkg::ProdW-1:0] mw3;
  logic [dtr_pkg::DenW-1:0]  den3;
  dtr_pkg::coord_t          c3 [3];
  logic                     wz3;

  always_comb begin
    logic [32:0]                mn;
    logic [dtr_pkg::NumW-1:0]   nn;
    logic [dtr_pkg::DenW+32:0]  lim;
    num3[0] = nx2_q;
    num3[1] = ny2_q;
    num3[2] = 34'(focal_q);
    wz3  = (w2_q == '0);
    mw3  = w2_q[dtr_pkg::ProdW] ? dtr_pkg::ProdW'(-w2_q) : dtr_pkg::ProdW'(w2_q);
    den3 = {mw3, 1'b0};
    lim  = (dtr_pkg::DenW + 33)'(den3) << dtr_pkg::QuoW;
    for (int i = 0; i < 3; i++) begin
      mn = num3[i][33] ? 33'(-num3[i]) : 33'(num3[i]);
      nn = (dtr_pkg::NumW'(mn) << (short_q ? 8 : 24));
      nn = (nn << 1) + dtr_pkg::NumW'(mw3);
      c3[i].rem = nn;
      c3[i].quo = '0;
      c3[i].neg = num3[i][33] ^ w2_q[dtr_pkg::ProdW];
      c3[i].zq  = wz3 && (mn == '0);
      c3[i].ovf = wz3 ? (mn != '0) : ((dtr_pkg::DenW + 33)'(nn) >= lim);
      if (wz3) c3[i].neg = num3[i][33];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int s = 0; s <= DivStg; s++) vd_q[s] <= 1'b0;
      done_o <= 1'b0;
    end else begin
      v1_q    <= start && !busy;
      v2_q    <= v1_q;
      vd_q[0] <= v2_q;
      for (int s = 0; s < DivStg; s++) vd_q[s+1] <= vd_q[s];
      done_o  <= vd_q[DivStg];
    end
  end

  // final comb
  logic [31:0] res [3];
  always_comb begin
    logic [32:0] nmag, plim, q;
    nmag = (out_mode_q == dtr_pkg::MODE_INT16) ? 33'd32768 : 33'h1_0000_0000 >> 1;
    plim = nmag - 33'd1;
    for (int i = 0; i < 3; i++) begin
      q = 33'(dv_q[DivStg][i].quo);
      if (dv_q[DivStg][i].zq) begin
        res[i] = '0;
      end else if (dv_q[DivStg][i].neg) begin
        res[i] = (dv_q[DivStg][i].ovf || q > nmag) ? 32'(-nmag) : 32'(-q);
      end else begin
        res[i] = (dv_q[DivStg][i].ovf || q > plim) ? 32'(plim) : 32'(q);
      end
    end
    if (miss_q[DivStg]) res[2] = short_q ? dtr_pkg::BIG_Z_INT : dtr_pkg::BIG_Z_Q16;
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= gain_q * disparity_i;
    px1_q   <= pixel_x_i[UseBits-1:0];
    py1_q   <= pixel_y_i[UseBits-1:0];
    miss1_q <= handle_miss_q && (disparity_i == miss_d_q);

    w2_q    <= 49'(prod1_q) + 49'(w_off_q);
    nx2_q   <= 34'({px2_dummy, 16'h0000}) + 34'(offset_x_q);
    ny2_q   <= 34'({py1_q, 16'h0000}) + 34'(offset_y_q);
    miss2_q <= miss1_q;

    for (int i = 0; i < 3; i++) dv_q[0][i] <= c3[i];
    den_q[0]  <= den3;
    miss_q[0] <= miss2_q;
    wz_q[0]   <= wz3;
    for (int s = 0; s < DivStg; s++) begin
      for (int i = 0; i < 3; i++)
        dv_q[s+1][i] <= dtr_pkg::div_step(dv_q[s][i], den_q[s], DivStg - 1 - s);
      miss_q[s+1] <= miss_q[s];
      wz_q[s+1]   <= wz_q[s];
    end
    for (int s = 0; s < DivStg - 1; s++) den_q[s+1] <= den_q[s];

    point_x_o <= res[0];
    point_y_o <= res[1];
    point_z_o <= res[2];
    w_zero_o  <= wz_q[DivStg];
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Lat done_o) else $error("result missing after fixed latency");
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy) else $error("busy raised");
  a_int16_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_mode_q == dtr_pkg::MODE_INT16 |->
      (point_x_o[31:15] == '0 || point_x_o[31:15] == '1))
    else $error("int16 result not sign extended");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(vd_q[DivStg])) else $error("result without transaction");

endmodule
